// ===== hdl/rth_pkg.sv =====
// Package for the RGB to HSL pixel converter: shared constants, pipeline
// record types and the restoring divider step used by the divider stages.
// No dependencies.
package rth_pkg;

  // Hue scale: one sector of 60 degrees in sixteenths of a degree.
  localparam int unsigned HUE_SECTOR = 960;
  localparam int unsigned HUE_FULL   = 6 * HUE_SECTOR;

  // Channel and arithmetic widths.
  localparam int unsigned CH_W    = 8;
  localparam int unsigned HUE_W   = 13;
  localparam int unsigned NUM_W   = 18;  // 255 * 960 needs 18 bits
  localparam int unsigned QUO_W   = 10;  // every quotient stays below 1024
  localparam int unsigned MAG_W   = QUO_W + 1;

  // Divider pipeline: two quotient bits per register stage.
  localparam int unsigned STEPS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES      = QUO_W / STEPS_PER_STAGE;

  // Which channel holds the maximum; ties go red, then green.
  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_t;

  // One divider lane: partial remainder, shifting numerator/quotient bits
  // and the divisor.
  typedef struct packed {
    logic [CH_W-1:0]  rem;
    logic [QUO_W-1:0] bits;
    logic [CH_W-1:0]  den;
  } div_lane_t;

  // Fields that ride alongside the divisions.
  typedef struct packed {
    sector_t         sector;
    logic            neg;
    logic            gray;
    logic [CH_W-1:0] light;
  } side_t;

  // One item in flight through the divider.
  typedef struct packed {
    div_lane_t hue;
    div_lane_t sat;
    side_t     side;
  } pipe_t;

  // One restoring division step: shift in the next numerator bit, subtract
  // the divisor when it fits, and shift the quotient bit in at the bottom.
  function automatic div_lane_t div_step(div_lane_t l);
    logic [CH_W:0] trial;
    logic          qbit;
    div_lane_t     res;
    trial   = {l.rem, l.bits[QUO_W-1]};
    qbit    = (trial >= {1'b0, l.den});
    res.den = l.den;
    if (qbit) begin
      res.rem = CH_W'(trial - {1'b0, l.den});
    end else begin
      res.rem = trial[CH_W-1:0];
    end
    res.bits = {l.bits[QUO_W-2:0], qbit};
    return res;
  endfunction

endpackage

// ===== hdl/rth_prep.sv =====
// Front end of the converter: two register stages that find max, min and
// chroma, then form the hue and saturation numerators and divisors.
// Depends on rth_pkg.
module rth_prep
  import rth_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  logic [CH_W-1:0] red,
  input  logic [CH_W-1:0] green,
  input  logic [CH_W-1:0] blue,
  output logic            dn_valid,
  input  logic            dn_ready,
  output pipe_t           dn_data
);

  // Stage one registers.
  logic            s1_valid_r;
  sector_t         s1_sector_r;
  logic [CH_W-1:0] s1_chroma_r;
  logic [CH_W:0]   s1_sum_r;
  logic            s1_neg_r;
  logic [CH_W-1:0] s1_mag_r;

  // Stage two registers.
  logic            s2_valid_r;
  pipe_t           s2_data_r;

  logic            s1_en;
  logic            s2_en;

  // Stage one combinational results.
  sector_t         sector_nxt;
  logic [CH_W-1:0] max_ch;
  logic [CH_W-1:0] min_ch;
  logic [CH_W:0]   diff;
  logic [CH_W-1:0] mag_nxt;

  // Stage two combinational results.
  logic [NUM_W-1:0] hue_num;
  logic [NUM_W-1:0] sat_num;
  logic [CH_W:0]    sum_dev;
  logic [CH_W-1:0]  sat_den;
  pipe_t            s2_data_nxt;

  // A stage loads when it is empty or its content moves on.
  assign s2_en    = !s2_valid_r || dn_ready;
  assign s1_en    = !s1_valid_r || s2_en;
  assign up_ready = s1_en;
  assign dn_valid = s2_valid_r;
  assign dn_data  = s2_data_r;

  // Pick the largest channel and the signed difference of the other two.
  always_comb begin
    if (red >= green && red >= blue) begin
      sector_nxt = SEC_RED;
      max_ch     = red;
      diff       = {1'b0, green} - {1'b0, blue};
    end else if (green >= blue) begin
      sector_nxt = SEC_GREEN;
      max_ch     = green;
      diff       = {1'b0, blue} - {1'b0, red};
    end else begin
      sector_nxt = SEC_BLUE;
      max_ch     = blue;
      diff       = {1'b0, red} - {1'b0, green};
    end
    min_ch = red;
    if (green < min_ch) begin
      min_ch = green;
    end
    if (blue < min_ch) begin
      min_ch = blue;
    end
    if (diff[CH_W]) begin
      mag_nxt = CH_W'(-diff);
    end else begin
      mag_nxt = diff[CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_en) begin
      s1_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_sector_r <= sector_nxt;
      s1_chroma_r <= max_ch - min_ch;
      s1_sum_r    <= {1'b0, max_ch} + {1'b0, min_ch};
      s1_neg_r    <= diff[CH_W];
      s1_mag_r    <= mag_nxt;
    end
  end

  // Numerators, saturation divisor and the divider lanes' start values.
  // The top numerator bits go straight into the remainder, since every
  // quotient fits in QUO_W bits.
  always_comb begin
    hue_num = NUM_W'(s1_mag_r) * NUM_W'(HUE_SECTOR);
    sat_num = NUM_W'(s1_chroma_r) * NUM_W'(8'd255);
    if (s1_sum_r >= 9'd255) begin
      sum_dev = s1_sum_r - 9'd255;
    end else begin
      sum_dev = 9'd255 - s1_sum_r;
    end
    sat_den = CH_W'(9'd255 - sum_dev);

    s2_data_nxt.hue.rem     = hue_num[NUM_W-1:QUO_W];
    s2_data_nxt.hue.bits    = hue_num[QUO_W-1:0];
    s2_data_nxt.hue.den     = s1_chroma_r;
    s2_data_nxt.sat.rem     = sat_num[NUM_W-1:QUO_W];
    s2_data_nxt.sat.bits    = sat_num[QUO_W-1:0];
    s2_data_nxt.sat.den     = sat_den;
    s2_data_nxt.side.sector = s1_sector_r;
    s2_data_nxt.side.neg    = s1_neg_r;
    s2_data_nxt.side.gray   = (s1_chroma_r == '0);
    s2_data_nxt.side.light  = s1_sum_r[CH_W:1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_data_r <= s2_data_nxt;
    end
  end

  // The restoring divider needs each starting remainder below its divisor.
  a_hue_rem_start: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && !s2_data_r.side.gray |-> s2_data_r.hue.rem < s2_data_r.hue.den)
    else $error("hue divider starts with remainder not below divisor");

  a_sat_rem_start: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && !s2_data_r.side.gray |-> s2_data_r.sat.rem < s2_data_r.sat.den)
    else $error("saturation divider starts with remainder not below divisor");

endmodule

// ===== hdl/rth_div_stage.sv =====
// One register stage of the pipelined divider: STEPS_PER_STAGE restoring
// steps on both the hue and the saturation lane.
// Depends on rth_pkg.
module rth_div_stage
  import rth_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  up_valid,
  output logic  up_ready,
  input  pipe_t up_data,
  output logic  dn_valid,
  input  logic  dn_ready,
  output pipe_t dn_data
);

  logic  valid_r;
  pipe_t data_r;
  pipe_t data_nxt;
  logic  en;

  assign en       = !valid_r || dn_ready;
  assign up_ready = en;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  // Chained division steps on both lanes; side fields pass unchanged.
  always_comb begin
    data_nxt = up_data;
    for (int unsigned i = 0; i < STEPS_PER_STAGE; i++) begin
      data_nxt.hue = div_step(data_nxt.hue);
      data_nxt.sat = div_step(data_nxt.sat);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  // A held item stays put until the next stage takes it.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !dn_ready |=> valid_r && $stable(data_r))
    else $error("divider stage lost or changed a stalled item");

endmodule

// ===== hdl/rth_post.sv =====
// Output stage: rounds the hue quotient toward minus infinity, adds the
// sector offset, zeroes hue and saturation for a gray pixel and registers the result fields.
// Depends on rth_pkg.
module rth_post
  import rth_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  pipe_t            up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output logic [HUE_W-1:0] hue,
  output logic [CH_W-1:0]  saturation,
  output logic [CH_W-1:0]  lightness
);

  logic             valid_r;
  logic [HUE_W-1:0] hue_r;
  logic [CH_W-1:0]  sat_r;
  logic [CH_W-1:0]  light_r;

  logic             en;
  logic [MAG_W-1:0] mag;
  logic [HUE_W-1:0] base;
  logic [HUE_W-1:0] hue_nxt;
  logic [CH_W-1:0]  sat_nxt;

  assign en         = !valid_r || dn_ready;
  assign up_ready   = en;
  assign dn_valid   = valid_r;
  assign hue        = hue_r;
  assign saturation = sat_r;
  assign lightness  = light_r;

  // A negative quotient with a remainder rounds one step further down.
  always_comb begin
    mag = {1'b0, up_data.hue.bits};
    if (up_data.side.neg && (up_data.hue.rem != '0)) begin
      mag = mag + MAG_W'(1);
    end
    case (up_data.side.sector)
      SEC_RED: begin
        base = up_data.side.neg ? HUE_W'(HUE_FULL) : '0;
      end
      SEC_GREEN: begin
        base = HUE_W'(2 * HUE_SECTOR);
      end
      SEC_BLUE: begin
        base = HUE_W'(4 * HUE_SECTOR);
      end
      default: begin
        base = '0;
      end
    endcase
    if (up_data.side.gray) begin
      hue_nxt = '0;
      sat_nxt = '0;
    end else begin
      if (up_data.side.neg) begin
        hue_nxt = base - HUE_W'(mag);
      end else begin
        hue_nxt = base + HUE_W'(mag);
      end
      sat_nxt = up_data.sat.bits[CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hue_r   <= hue_nxt;
      sat_r   <= sat_nxt;
      light_r <= up_data.side.light;
    end
  end

  // Quotients out of the divider stay inside their ranges.
  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    up_valid && !up_data.side.gray |->
      up_data.hue.bits <= QUO_W'(HUE_SECTOR) && up_data.sat.bits[QUO_W-1:CH_W] == '0)
    else $error("divider quotient out of range");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> hue_r < HUE_W'(HUE_FULL))
    else $error("hue result not below a full circle");

endmodule

// ===== hdl/rgb_to_hsl_pixel.sv =====
// Top level of the RGB to HSL pixel converter: front end, divider stages
// and output stage in one pipeline.
// Depends on rth_pkg, rth_prep, rth_div_stage and rth_post.
//
// Usage:
//   One 8-bit RGB pixel is a transfer on the input channel (in_valid,
//   in_ready, in_red, in_green, in_blue). Each pixel gives exactly one
//   result transfer on the output channel (out_valid, out_ready, out_hue,
//   out_saturation, out_lightness), in input order. Hue is in sixteenths
//   of a degree (0..5759), saturation and lightness are on a 0..255 scale.
//   A gray pixel gives hue 0 and saturation 0.
//   The pixel passes eight register stages: two front-end stages, five
//   divider stages at two quotient bits each, and the output register.
//   With out_ready held high, throughput is one pixel per cycle, set
//   by the fully pipelined divider.
//   Every stage carries its own valid bit and loads when it is empty or
//   its content moves on, so a stall at the output fills empty stages
//   before in_ready drops, and no pixel is lost or repeated.
//   Reset clears all valid bits; the data registers are not reset.
module rgb_to_hsl_pixel
  import rth_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CH_W-1:0]  in_red,
  input  logic [CH_W-1:0]  in_green,
  input  logic [CH_W-1:0]  in_blue,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [HUE_W-1:0] out_hue,
  output logic [CH_W-1:0]  out_saturation,
  output logic [CH_W-1:0]  out_lightness
);

  // Links between stages: link 0 leaves the front end, the last link
  // enters the output stage.
  logic  link_valid [DIV_STAGES+1];
  logic  link_ready [DIV_STAGES+1];
  pipe_t link_data  [DIV_STAGES+1];

  // Front end.
  rth_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .red      (in_red),
    .green    (in_green),
    .blue     (in_blue),
    .dn_valid (link_valid[0]),
    .dn_ready (link_ready[0]),
    .dn_data  (link_data[0])
  );

  // Divider stages.
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    rth_div_stage u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (link_valid[s]),
      .up_ready (link_ready[s]),
      .up_data  (link_data[s]),
      .dn_valid (link_valid[s+1]),
      .dn_ready (link_ready[s+1]),
      .dn_data  (link_data[s+1])
    );
  end

  // Output stage.
  rth_post u_post (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (link_valid[DIV_STAGES]),
    .up_ready   (link_ready[DIV_STAGES]),
    .up_data    (link_data[DIV_STAGES]),
    .dn_valid   (out_valid),
    .dn_ready   (out_ready),
    .hue        (out_hue),
    .saturation (out_saturation),
    .lightness  (out_lightness)
  );

endmodule
